// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro takes a label, the clock and the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle as its condition.
`define RKD_ASSERT_IMPLY(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Property holds in the cycle after its condition.
`define RKD_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

// File: hdl/rkd_pkg.sv
// Package for the RSA key derivation block: widths, micro-operations, status and controller states.
// Depends on nothing.
`default_nettype none
package rkd_pkg;
	localparam int KEY_BITS = 64;
	localparam int CNT_BITS = $clog2(KEY_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(KEY_BITS - 1);

	typedef logic [KEY_BITS-1:0] key_t;

	// Micro-operations the controller issues to the datapath.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_INIT_N,
		OP_MUL_STEP,
		OP_STORE_N_INIT_PHI,
		OP_STORE_PHI,
		OP_GCD_INIT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_GCD_NEXT,
		OP_E_INC,
		OP_INV_INIT,
		OP_MUL_INIT_C1,
		OP_INV_UPDATE,
		OP_FINISH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic e_lt_phi;
		logic rem_zero;
		logic b_is_one;
		logic b_zero;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MN0, S_MN, S_MP0, S_MP, S_PHI, S_SRCH, S_GD0, S_GD, S_GCHK,
		S_INV0, S_ILOOP, S_ID, S_IM0, S_IM, S_IUPD, S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: hdl/rkd_datapath.sv
// Datapath: operand registers, a bit-serial multiplier and a restoring divider.
// Depends on rkd_pkg; driven by rkd_ctrl.
`default_nettype none
module rkd_datapath (
	input  wire logic          clk,
	input  wire rkd_pkg::cmd_t cmd,
	input  wire logic [31:0]   prime_p,
	input  wire logic [31:0]   prime_q,
	output rkd_pkg::stat_t     stat,
	output rkd_pkg::key_t      modulus,
	output rkd_pkg::key_t      totient,
	output rkd_pkg::key_t      public_exp,
	output rkd_pkg::key_t      private_exp,
	output logic               key_valid
);
	import rkd_pkg::*;

	key_t p_q, q_q, n_q, phi_q, e_q;
	key_t mx_q, my_q, acc_q;
	key_t div_a_q, div_b_q, dd_q, rem_q;
	key_t a1_q, b1_q;
	logic neg_q;
	key_t mod_q, tot_q, pub_q, priv_q;
	logic ok_q;

	logic [KEY_BITS:0] rem_shift;
	logic              rem_ge;
	key_t              rem_sub;
	key_t              d_val;

	// One restoring division step: shift in the next dividend bit and try to subtract.
	always_comb begin
		rem_shift = {rem_q, dd_q[KEY_BITS-1]};
		rem_ge    = rem_shift >= {1'b0, div_b_q};
		rem_sub   = KEY_BITS'(rem_shift - {1'b0, div_b_q});
	end

	// Private exponent selection from the final Euclid state.
	always_comb begin
		d_val = neg_q ? (phi_q - a1_q) : a1_q;
	end

	// Operand and result registers, updated by micro-operation.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				p_q <= KEY_BITS'(prime_p);
				q_q <= KEY_BITS'(prime_q);
			end
			OP_MUL_INIT_N: begin
				mx_q  <= p_q;
				my_q  <= q_q;
				acc_q <= '0;
			end
			OP_MUL_STEP: begin
				if (my_q[0]) begin
					acc_q <= acc_q + mx_q;
				end
				mx_q <= {mx_q[KEY_BITS-2:0], 1'b0};
				my_q <= {1'b0, my_q[KEY_BITS-1:1]};
			end
			OP_STORE_N_INIT_PHI: begin
				n_q   <= acc_q;
				mx_q  <= p_q - KEY_BITS'(1);
				my_q  <= q_q - KEY_BITS'(1);
				acc_q <= '0;
			end
			OP_STORE_PHI: begin
				phi_q <= acc_q;
				e_q   <= KEY_BITS'(2);
			end
			OP_GCD_INIT: begin
				div_a_q <= e_q;
				div_b_q <= phi_q;
			end
			OP_DIV_INIT: begin
				dd_q  <= div_a_q;
				rem_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= rem_ge ? rem_sub : rem_shift[KEY_BITS-1:0];
				dd_q  <= {dd_q[KEY_BITS-2:0], rem_ge};
			end
			OP_GCD_NEXT: begin
				div_a_q <= div_b_q;
				div_b_q <= rem_q;
			end
			OP_E_INC: begin
				e_q <= e_q + KEY_BITS'(1);
			end
			OP_INV_INIT: begin
				a1_q    <= KEY_BITS'(1);
				b1_q    <= '0;
				div_a_q <= e_q;
				div_b_q <= phi_q;
				neg_q   <= 1'b0;
			end
			OP_MUL_INIT_C1: begin
				mx_q  <= dd_q;
				my_q  <= b1_q;
				acc_q <= a1_q;
			end
			OP_INV_UPDATE: begin
				a1_q    <= b1_q;
				b1_q    <= acc_q;
				div_a_q <= div_b_q;
				div_b_q <= rem_q;
				neg_q   <= !neg_q;
			end
			OP_FINISH: begin
				mod_q  <= n_q;
				tot_q  <= phi_q;
				pub_q  <= e_q;
				ok_q   <= div_a_q == KEY_BITS'(1);
				priv_q <= (div_a_q == KEY_BITS'(1)) ? d_val : '0;
			end
			default: begin
			end
		endcase
	end

	// Status back to the controller.
	always_comb begin
		stat.e_lt_phi = e_q < phi_q;
		stat.rem_zero = rem_q == '0;
		stat.b_is_one = div_b_q == KEY_BITS'(1);
		stat.b_zero   = div_b_q == '0;
	end

	assign modulus     = mod_q;
	assign totient     = tot_q;
	assign public_exp  = pub_q;
	assign private_exp = priv_q;
	assign key_valid   = ok_q;
endmodule
`default_nettype wire

// File: hdl/rkd_ctrl.sv
// Controller: sequences the multiply, gcd search and inverse loops, owns the handshakes.
// Depends on rkd_pkg; drives rkd_datapath.
`default_nettype none
module rkd_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire rkd_pkg::stat_t stat,
	output rkd_pkg::cmd_t       cmd
);
	import rkd_pkg::*;

	state_t state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic cnt_clr, last;
	logic out_valid_q;

	assign last = cnt_q == CNT_LAST;

	// State, step counter and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_clr ? '0 : cnt_q + CNT_BITS'(1);
			if (cmd.op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and micro-operation.
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cnt_clr  = 1'b1;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_MN0;
				end
			end
			S_MN0: begin
				cmd.op  = OP_MUL_INIT_N;
				state_d = S_MN;
			end
			S_MN: begin
				cmd.op  = OP_MUL_STEP;
				cnt_clr = last;
				if (last) state_d = S_MP0;
			end
			// The modulus product hands over to the totient product in the single state S_MP0.
			S_MP0: begin
				cmd.op  = OP_STORE_N_INIT_PHI;
				state_d = S_MP;
			end
			S_MP: begin
				cmd.op  = OP_MUL_STEP;
				cnt_clr = last;
				if (last) state_d = S_PHI;
			end
			S_PHI: begin
				cmd.op  = OP_STORE_PHI;
				state_d = S_SRCH;
			end
			S_SRCH: begin
				if (stat.e_lt_phi) begin
					cmd.op  = OP_GCD_INIT;
					state_d = S_GD0;
				end else begin
					state_d = S_INV0;
				end
			end
			S_GD0: begin
				cmd.op  = OP_DIV_INIT;
				state_d = S_GD;
			end
			S_GD: begin
				cmd.op  = OP_DIV_STEP;
				cnt_clr = last;
				if (last) state_d = S_GCHK;
			end
			S_GCHK: begin
				if (!stat.rem_zero) begin
					cmd.op  = OP_GCD_NEXT;
					state_d = S_GD0;
				end else if (stat.b_is_one) begin
					state_d = S_INV0;
				end else begin
					cmd.op  = OP_E_INC;
					state_d = S_SRCH;
				end
			end
			S_INV0: begin
				cmd.op  = OP_INV_INIT;
				state_d = S_ILOOP;
			end
			S_ILOOP: begin
				if (stat.b_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_DIV_INIT;
					state_d = S_ID;
				end
			end
			S_ID: begin
				cmd.op  = OP_DIV_STEP;
				cnt_clr = last;
				if (last) state_d = S_IM0;
			end
			S_IM0: begin
				cmd.op  = OP_MUL_INIT_C1;
				state_d = S_IM;
			end
			S_IM: begin
				cmd.op  = OP_MUL_STEP;
				cnt_clr = last;
				if (last) state_d = S_IUPD;
			end
			S_IUPD: begin
				cmd.op  = OP_INV_UPDATE;
				state_d = S_ILOOP;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = OP_FINISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: hdl/rsa_key_derivation_top.sv
// Channel   Signals                                          Direction
// input     in_valid, in_ready, prime_p, prime_q             in
// output    out_valid, out_ready, modulus, totient,          out
//           public_exp, private_exp, key_valid
// One key pair at a time. The two products run on a bit-serial multiplier; every Euclid
// remainder runs on the restoring divider, and each inverse step adds a further product,
// so the total grows with the number of gcd steps.
// Reset clears only control; the output word may wait for out_ready while a new pair is
// accepted, and the result of that pair is held back until the old word is taken.
// Depends on rkd_pkg, rkd_ctrl and rkd_datapath.
`default_nettype none
module rsa_key_derivation_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] prime_p,
	input  wire logic [31:0] prime_q,
	output logic             out_valid,
	input  wire logic        out_ready,
	output rkd_pkg::key_t    modulus,
	output rkd_pkg::key_t    totient,
	output rkd_pkg::key_t    public_exp,
	output rkd_pkg::key_t    private_exp,
	output logic             key_valid
);
	import rkd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	rkd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic and result registers.
	rkd_datapath u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.prime_p     (prime_p),
		.prime_q     (prime_q),
		.stat        (stat),
		.modulus     (modulus),
		.totient     (totient),
		.public_exp  (public_exp),
		.private_exp (private_exp),
		.key_valid   (key_valid)
	);
endmodule
`default_nettype wire

// File: hdl/rkd_checker.sv
// Port-level checks for rsa_key_derivation_top, attached by bind.
// Depends on rkd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rkd_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire rkd_pkg::key_t totient,
	input wire rkd_pkg::key_t public_exp,
	input wire rkd_pkg::key_t private_exp,
	input wire logic          key_valid
);
	import rkd_pkg::*;

	// A word that is not taken stays offered.
	`RKD_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// Without an inverse the private exponent reads zero.
	`RKD_ASSERT_IMPLY(a_noinv, clk, arst_n, out_valid && !key_valid, private_exp == '0)
	// The exponent search starts at two.
	`RKD_ASSERT_IMPLY(a_emin, clk, arst_n, out_valid, public_exp >= KEY_BITS'(2))
	// A small totient skips the search.
	`RKD_ASSERT_IMPLY(a_small, clk, arst_n, out_valid && totient <= KEY_BITS'(2), public_exp == KEY_BITS'(2))
endmodule

bind rsa_key_derivation_top rkd_checker u_rkd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.totient     (totient),
	.public_exp  (public_exp),
	.private_exp (private_exp),
	.key_valid   (key_valid)
);
`default_nettype wire
